FILE: rtl/tmsc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tmsc_pkg
// Shared sizes, register codes and bus types for the toroidal spacing check.
// ----------------------------------------------------------------------------
package tmsc_pkg;

  localparam int MAX_POINTS = 1024;
  localparam int N_CELLS    = 4;
  localparam int BANK_DEPTH = MAX_POINTS / N_CELLS;

  localparam int IDX_W    = $clog2(MAX_POINTS);
  localparam int BANK_AW  = $clog2(BANK_DEPTH);
  localparam int CELL_W   = $clog2(N_CELLS);
  localparam int CNT_W    = IDX_W + 1;
  localparam int EXC_W    = 11;
  localparam int COORD_W  = 16;
  localparam int FRAC_W   = 4;
  localparam int CFG_W    = 12;
  localparam int WRAP_W   = COORD_W + 2;
  localparam int SQ_W     = 2 * COORD_W;
  localparam int SUM_W    = SQ_W + 1;
  localparam int SP2_W    = 2 * CFG_W;
  localparam int PADDR_W  = 4;
  localparam int PDATA_W  = 32;
  localparam int REG_IDX_W = 2;

  localparam logic [REG_IDX_W-1:0] REG_FIELD_WIDTH  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_FIELD_HEIGHT = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_MIN_SPACING  = 2'd2;

  localparam logic OP_STORE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [CFG_W-1:0] FIELD_WIDTH_RST  = 12'd1024;
  localparam logic [CFG_W-1:0] FIELD_HEIGHT_RST = 12'd1024;
  localparam logic [CFG_W-1:0] MIN_SPACING_RST  = 12'd256;

  typedef struct packed {
    logic               valid;
    logic [BANK_AW-1:0] addr;
    logic               acc;
  } beat_t;

  typedef struct packed {
    logic [COORD_W-1:0] pos_x;
    logic [COORD_W-1:0] pos_y;
    logic [CNT_W-1:0]   count;
    logic [EXC_W-1:0]   except_index;
  } query_t;

  typedef struct packed {
    logic [CFG_W-1:0] field_width;
    logic [CFG_W-1:0] field_height;
    logic [CFG_W-1:0] min_spacing;
    logic [SP2_W-1:0] sp2;
  } cfg_t;

  typedef struct packed {
    logic               en;
    logic [IDX_W-1:0]   idx;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } wr_t;

endpackage
`default_nettype wire

FILE: rtl/tmsc_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tmsc_cell
// One bank of stored points with a five-stage distance pipeline; ORs its own
// hit into the word passed on to the next cell.
// ----------------------------------------------------------------------------
module tmsc_cell (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic [tmsc_pkg::CELL_W-1:0] cell_id,
  input  wire tmsc_pkg::query_t            query,
  input  wire tmsc_pkg::cfg_t              cfg,
  input  wire tmsc_pkg::wr_t               wr,
  input  wire tmsc_pkg::beat_t             beat_in,
  output tmsc_pkg::beat_t                  beat_out
);
  import tmsc_pkg::*;

  logic [COORD_W-1:0] mem_x [BANK_DEPTH];
  logic [COORD_W-1:0] mem_y [BANK_DEPTH];

  beat_t s1_beat_r, s2_beat_r, s3_beat_r, s4_beat_r, out_beat_r;
  logic [COORD_W-1:0] rx_r, ry_r;
  logic [COORD_W-1:0] s2_adx_r, s2_ady_r;
  logic               s2_en_r;
  logic [COORD_W-1:0] s3_magx_r, s3_magy_r;
  logic               s3_ok_r;
  logic [SQ_W-1:0]    s4_sqx_r, s4_sqy_r;
  logic               s4_ok_r;

  logic [IDX_W-1:0]          n_idx;
  logic                      en;
  logic signed [COORD_W:0]   dx_s, dy_s, ndx_s, ndy_s;
  logic [COORD_W-1:0]        adx, ady;
  logic [COORD_W-1:0]        full_x, full_y, half_x, half_y;
  logic signed [WRAP_W-1:0]  wx, wy, nwx, nwy, sp_ext;
  logic                      pass_x, pass_y;
  logic [SUM_W-1:0]          sum_sq;
  logic                      hit;

  // table write
  always_ff @(posedge clk) begin
    if (wr.en && (wr.idx[IDX_W-1:BANK_AW] == cell_id)) begin
      mem_x[wr.idx[BANK_AW-1:0]] <= wr.x;
      mem_y[wr.idx[BANK_AW-1:0]] <= wr.y;
    end
  end

  // stage 1: table read
  always_ff @(posedge clk) begin
    rx_r <= mem_x[beat_in.addr];
    ry_r <= mem_y[beat_in.addr];
  end

  // stage 2: absolute axis differences, scan window
  assign n_idx = {cell_id, s1_beat_r.addr};
  assign en    = (CNT_W'(n_idx) < query.count) && (EXC_W'(n_idx) != query.except_index);
  assign dx_s  = $signed({rx_r[COORD_W-1], rx_r}) -
                 $signed({query.pos_x[COORD_W-1], query.pos_x});
  assign dy_s  = $signed({ry_r[COORD_W-1], ry_r}) -
                 $signed({query.pos_y[COORD_W-1], query.pos_y});
  assign ndx_s = -dx_s;
  assign ndy_s = -dy_s;
  assign adx   = dx_s[COORD_W] ? ndx_s[COORD_W-1:0] : dx_s[COORD_W-1:0];
  assign ady   = dy_s[COORD_W] ? ndy_s[COORD_W-1:0] : dy_s[COORD_W-1:0];

  always_ff @(posedge clk) begin
    s2_adx_r <= adx;
    s2_ady_r <= ady;
    s2_en_r  <= en;
  end

  // stage 3: wrap around the field, per-axis test
  assign full_x = {cfg.field_width, {FRAC_W{1'b0}}};
  assign full_y = {cfg.field_height, {FRAC_W{1'b0}}};
  assign half_x = {1'b0, cfg.field_width, {(FRAC_W-1){1'b0}}};
  assign half_y = {1'b0, cfg.field_height, {(FRAC_W-1){1'b0}}};
  assign sp_ext = $signed({{(WRAP_W-CFG_W){1'b0}}, cfg.min_spacing});

  assign wx = (s2_adx_r > half_x) ?
              $signed({2'b00, full_x}) - $signed({2'b00, s2_adx_r}) :
              $signed({2'b00, s2_adx_r});
  assign wy = (s2_ady_r > half_y) ?
              $signed({2'b00, full_y}) - $signed({2'b00, s2_ady_r}) :
              $signed({2'b00, s2_ady_r});
  assign nwx    = -wx;
  assign nwy    = -wy;
  assign pass_x = (wx <= sp_ext);
  assign pass_y = (wy <= sp_ext);

  always_ff @(posedge clk) begin
    s3_magx_r <= wx[WRAP_W-1] ? nwx[COORD_W-1:0] : wx[COORD_W-1:0];
    s3_magy_r <= wy[WRAP_W-1] ? nwy[COORD_W-1:0] : wy[COORD_W-1:0];
    s3_ok_r   <= s2_en_r && pass_x && pass_y;
  end

  // stage 4: squares
  always_ff @(posedge clk) begin
    s4_sqx_r <= SQ_W'(s3_magx_r) * SQ_W'(s3_magx_r);
    s4_sqy_r <= SQ_W'(s3_magy_r) * SQ_W'(s3_magy_r);
    s4_ok_r  <= s3_ok_r;
  end

  // stage 5: radius test, merge into the passing word
  assign sum_sq = {1'b0, s4_sqx_r} + {1'b0, s4_sqy_r};
  assign hit    = s4_ok_r && (sum_sq <= {{(SUM_W-SP2_W){1'b0}}, cfg.sp2});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_beat_r.valid  <= 1'b0;
      s2_beat_r.valid  <= 1'b0;
      s3_beat_r.valid  <= 1'b0;
      s4_beat_r.valid  <= 1'b0;
      out_beat_r.valid <= 1'b0;
    end else begin
      s1_beat_r  <= beat_in;
      s2_beat_r  <= s1_beat_r;
      s3_beat_r  <= s2_beat_r;
      s4_beat_r  <= s3_beat_r;
      out_beat_r <= '{valid: s4_beat_r.valid,
                      addr:  s4_beat_r.addr,
                      acc:   s4_beat_r.acc | (s4_beat_r.valid & hit)};
    end
  end

  assign beat_out = out_beat_r;

endmodule
`default_nettype wire

FILE: rtl/toroidal_min_spacing_check.sv
`default_nettype none
// ----------------------------------------------------------------------------
// toroidal_min_spacing_check
// Point table in a wrap-around field with a minimum spacing query.
//
// Input words (in_valid/in_ready) carry either a store (in_op = 0), which
// writes in_pos_x/in_pos_y at in_index when accepted and gives no result, or a
// query (in_op = 1), which checks the candidate against entries 0 to
// in_count-1, skipping in_except_index, and gives one out_too_close word.
// The table is split over 4 cells of 256 entries; all cells scan their banks
// in step while one word per address walks down the chain, each cell having
// its own pipeline of table read, differences, wrap test, squares and radius
// test. in_ready stays low from a query's acceptance until its result moves
// to the output register; stores are taken whenever the block is idle.
// Field size and spacing are written over the APB port at 0x0, 0x4, 0x8.
// Reset restores the register defaults (1024, 1024, 256) and clears control
// state; table contents stay undefined until written. A result waiting on
// out_ready does not block new input; a finished query holds until the
// output register is free.
// ----------------------------------------------------------------------------
module toroidal_min_spacing_check (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          in_op,
  input  wire logic [9:0]                    in_index,
  input  wire logic signed [15:0]            in_pos_x,
  input  wire logic signed [15:0]            in_pos_y,
  input  wire logic [10:0]                   in_count,
  input  wire logic [10:0]                   in_except_index,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               out_too_close,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [tmsc_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [tmsc_pkg::PDATA_W-1:0]  pwdata,
  output logic [tmsc_pkg::PDATA_W-1:0]       prdata,
  output logic                               pready
);
  import tmsc_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_DRAIN  = 2'd2;
  localparam logic [1:0] ST_RESULT = 2'd3;

  logic [1:0]         state_r;
  logic [BANK_AW-1:0] addr_r;
  logic               hit_r;
  query_t             query_r;
  logic               out_valid_r, out_too_close_r;

  logic [CFG_W-1:0]   field_width_r, field_height_r, min_spacing_r;
  logic [SP2_W-1:0]   sp2_r;

  logic               cfg_wr;
  logic [REG_IDX_W-1:0] reg_idx;
  logic               in_acc, out_free;
  logic [CNT_W-1:0]   count_sat;
  cfg_t               cfg;
  wr_t                wr;
  beat_t              beat_w [N_CELLS+1];

  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      field_width_r  <= FIELD_WIDTH_RST;
      field_height_r <= FIELD_HEIGHT_RST;
      min_spacing_r  <= MIN_SPACING_RST;
      sp2_r          <= SP2_W'(MIN_SPACING_RST) * SP2_W'(MIN_SPACING_RST);
    end else begin
      sp2_r <= SP2_W'(min_spacing_r) * SP2_W'(min_spacing_r);
      if (cfg_wr) begin
        unique case (reg_idx)
          REG_FIELD_WIDTH:  field_width_r  <= pwdata[CFG_W-1:0];
          REG_FIELD_HEIGHT: field_height_r <= pwdata[CFG_W-1:0];
          REG_MIN_SPACING:  min_spacing_r  <= pwdata[CFG_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_FIELD_WIDTH:  prdata = PDATA_W'(field_width_r);
      REG_FIELD_HEIGHT: prdata = PDATA_W'(field_height_r);
      REG_MIN_SPACING:  prdata = PDATA_W'(min_spacing_r);
      default:          prdata = '0;
    endcase
  end

  assign cfg = '{field_width:  field_width_r,
                 field_height: field_height_r,
                 min_spacing:  min_spacing_r,
                 sp2:          sp2_r};

  assign in_ready  = (state_r == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign count_sat = (in_count > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : in_count;

  assign wr = '{en:  in_acc && (in_op == OP_STORE),
                idx: in_index[IDX_W-1:0],
                x:   in_pos_x,
                y:   in_pos_y};

  always_ff @(posedge clk) begin
    if (in_acc && (in_op == OP_QUERY)) begin
      query_r <= '{pos_x: in_pos_x, pos_y: in_pos_y,
                   count: count_sat, except_index: in_except_index};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      addr_r      <= '0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc && (in_op == OP_QUERY)) begin
        hit_r <= 1'b0;
      end else if (beat_w[N_CELLS].valid && beat_w[N_CELLS].acc) begin
        hit_r <= 1'b1;
      end
      if ((state_r == ST_RESULT) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc && (in_op == OP_QUERY)) begin
            state_r <= ST_SCAN;
            addr_r  <= '0;
          end
        end
        ST_SCAN: begin
          addr_r <= addr_r + 1'b1;
          if (addr_r == BANK_AW'(BANK_DEPTH - 1)) begin
            state_r <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (beat_w[N_CELLS].valid && (beat_w[N_CELLS].addr == BANK_AW'(BANK_DEPTH - 1))) begin
            state_r <= ST_RESULT;
          end
        end
        ST_RESULT: begin
          if (out_free) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_RESULT) && out_free) begin
      out_too_close_r <= hit_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_too_close = out_too_close_r;

  assign beat_w[0] = '{valid: (state_r == ST_SCAN), addr: addr_r, acc: 1'b0};

  for (genvar c = 0; c < N_CELLS; c++) begin : g_cell
    tmsc_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_id  (CELL_W'(c)),
      .query    (query_r),
      .cfg      (cfg),
      .wr       (wr),
      .beat_in  (beat_w[c]),
      .beat_out (beat_w[c+1])
    );
  end

endmodule
`default_nettype wire

FILE: bench/toroidal_min_spacing_check_test.sv
`default_nettype none
// ----------------------------------------------------------------------------
// toroidal_min_spacing_check_test
// Self-checking bench for the wrap-around point table and spacing query.
//
// A short table of directed words covers the corner cases: exact hits, the
// spacing boundary, excluded entries, far-edge wrap, points outside the
// field, zero field size and the register extremes. After that come random
// phases, each with its own field and spacing setup. Queries mostly land near
// stored points so that hits and misses both occur. One phase fills the
// lower part of the table, past the first bank, for long scans. A bit-true
// predictor keeps its own copy of the table and the registers. Every out
// word is compared with the oldest pending too_close flag. Both channels
// idle at random, and the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module toroidal_min_spacing_check_test;
  import tmsc_pkg::*;

  localparam int RANDOM_WORDS = 520;
  localparam int FILL_TARGET  = 320;
  localparam int HOLD_CYCLES  = 1500;
  localparam int STALL_LIMIT  = 20000;
  localparam int N_DIRECTED   = 23;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef enum bit {ROW_WORD, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t            kind;
    logic                 op;
    logic [IDX_W-1:0]     idx;
    coord_t               x;
    coord_t               y;
    logic [CNT_W-1:0]     cnt;
    logic [EXC_W-1:0]     exc;
    bit                   known;
    bit                   hit;
    logic [REG_IDX_W-1:0] which;
    logic [CFG_W-1:0]     value;
  } row_t;

  logic                clk;
  logic                rst_n           = 1'b0;
  logic                in_valid        = 1'b0;
  logic                in_ready;
  logic                in_op           = OP_STORE;
  logic [IDX_W-1:0]    in_index        = '0;
  coord_t              in_pos_x        = '0;
  coord_t              in_pos_y        = '0;
  logic [CNT_W-1:0]    in_count        = '0;
  logic [EXC_W-1:0]    in_except_index = '0;
  logic                out_valid;
  logic                out_ready       = 1'b0;
  logic                out_too_close;
  logic                psel            = 1'b0;
  logic                penable         = 1'b0;
  logic                pwrite          = 1'b0;
  logic [PADDR_W-1:0]  paddr           = '0;
  logic [PDATA_W-1:0]  pwdata          = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  coord_t              point_x [MAX_POINTS];
  coord_t              point_y [MAX_POINTS];
  bit                  point_set [MAX_POINTS];
  int                  fill_mark = 0;
  logic [CFG_W-1:0]    field_w = FIELD_WIDTH_RST;
  logic [CFG_W-1:0]    field_h = FIELD_HEIGHT_RST;
  logic [CFG_W-1:0]    spacing = MIN_SPACING_RST;
  bit                  expected_flags [$];

  int                  error_count   = 0;
  int                  random_sent   = 0;
  int                  burst_left    = 0;
  bit                  steady        = 1'b0;
  bit                  hold_request  = 1'b0;
  int                  quiet_cycles  = 0;
  row_t                directed [N_DIRECTED];

  toroidal_min_spacing_check dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_op           (in_op),
    .in_index        (in_index),
    .in_pos_x        (in_pos_x),
    .in_pos_y        (in_pos_y),
    .in_count        (in_count),
    .in_except_index (in_except_index),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_too_close   (out_too_close),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // wrapped distance along one axis, size in whole pixels
  function automatic longint wrap_dist(input coord_t a, input coord_t b,
                                       input logic [CFG_W-1:0] size);
    longint d;
    longint full;
    d = longint'(a) - longint'(b);
    full = longint'(size) * 16;
    if (d < 0) d = -d;
    if (2 * d > full) d = full - d;
    return d;
  endfunction

  function automatic bit spacing_violated(input coord_t cx, input coord_t cy,
                                          input logic [CNT_W-1:0] cnt,
                                          input logic [EXC_W-1:0] exc);
    longint sp;
    longint sp2;
    longint dx;
    longint dy;
    int     lim;
    sp = longint'(spacing);
    sp2 = sp * sp;
    lim = (cnt > MAX_POINTS) ? MAX_POINTS : int'(cnt);
    for (int n = 0; n < lim; n++) begin
      if (n == int'(exc)) continue;
      dx = wrap_dist(point_x[n], cx, field_w);
      if (dx > sp) continue;
      dy = wrap_dist(point_y[n], cy, field_h);
      if (dy > sp) continue;
      if (dx * dx + dy * dy <= sp2) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic row_t checked_row(input int x, input int y, input int cnt,
                                       input int exc, input bit hit);
    row_t r;
    r.kind  = ROW_WORD;
    r.op    = OP_QUERY;
    r.idx   = '0;
    r.x     = coord_t'(x);
    r.y     = coord_t'(y);
    r.cnt   = CNT_W'(cnt);
    r.exc   = EXC_W'(exc);
    r.known = 1'b1;
    r.hit   = hit;
    r.which = '0;
    r.value = '0;
    return r;
  endfunction

  function automatic row_t query_row(input int x, input int y, input int cnt,
                                     input int exc);
    row_t r;
    r = checked_row(x, y, cnt, exc, 1'b0);
    r.known = 1'b0;
    return r;
  endfunction

  function automatic row_t store_row(input int idx, input int x, input int y);
    row_t r;
    r = query_row(x, y, 0, 0);
    r.op  = OP_STORE;
    r.idx = IDX_W'(idx);
    return r;
  endfunction

  function automatic row_t setting_row(input logic [REG_IDX_W-1:0] which,
                                       input int value);
    row_t r;
    r = query_row(0, 0, 0, 0);
    r.kind  = ROW_CFG;
    r.which = which;
    r.value = CFG_W'(value);
    return r;
  endfunction

  task automatic send_word(input logic op, input logic [IDX_W-1:0] idx,
                           input coord_t x, input coord_t y,
                           input logic [CNT_W-1:0] cnt,
                           input logic [EXC_W-1:0] exc,
                           input bit known, input bit hit);
    int gap;
    in_valid        <= 1'b1;
    in_op           <= op;
    in_index        <= idx;
    in_pos_x        <= x;
    in_pos_y        <= y;
    in_count        <= cnt;
    in_except_index <= exc;
    do @(posedge clk); while (!in_ready);
    if (op == OP_STORE) begin
      point_x[idx] = x;
      point_y[idx] = y;
      point_set[idx] = 1'b1;
      while (fill_mark < MAX_POINTS && point_set[fill_mark]) fill_mark++;
    end else begin
      expected_flags.push_back(known ? hit : spacing_violated(x, y, cnt, exc));
    end
    if (!steady) begin
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80)
                                                 : $urandom_range(1, 8);
        gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 60)
                                          : $urandom_range(1, 4);
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic send_random(input bit query_only);
    logic             op;
    logic [IDX_W-1:0] idx;
    coord_t           x;
    coord_t           y;
    logic [CNT_W-1:0] cnt;
    logic [EXC_W-1:0] exc;
    int               n;
    int               lim;
    int               span;
    int               pick;
    op  = (query_only || $urandom_range(0, 99) < 50) ? OP_QUERY : OP_STORE;
    idx = IDX_W'($urandom);
    x   = coord_t'($urandom);
    y   = coord_t'($urandom);
    cnt = '0;
    exc = EXC_W'($urandom);
    span = int'(spacing) + 8;
    pick = $urandom_range(0, 9);
    if (op == OP_STORE) begin
      if (fill_mark < MAX_POINTS && pick < 5) idx = IDX_W'(fill_mark);
      if (pick >= 7 && fill_mark > 0) begin
        n = $urandom_range(0, fill_mark - 1);
        x = coord_t'(int'(point_x[n]) + int'($urandom_range(0, 2 * span)) - span);
        y = coord_t'(int'(point_y[n]) + int'($urandom_range(0, 2 * span)) - span);
      end else if (pick >= 5) begin
        x = coord_t'($urandom_range(0, int'(field_w) * 16));
        y = coord_t'($urandom_range(0, int'(field_h) * 16));
      end
    end else begin
      if (fill_mark > 0) begin
        case ($urandom_range(0, 9))
          0: cnt = '0;
          1, 2: cnt = CNT_W'(fill_mark);
          3: cnt = (fill_mark == MAX_POINTS) ? CNT_W'($urandom_range(MAX_POINTS, 2047))
                                             : CNT_W'(fill_mark);
          default: cnt = CNT_W'($urandom_range(1, fill_mark));
        endcase
      end
      case ($urandom_range(0, 4))
        0: exc = EXC_W'($urandom);
        1: exc = EXC_W'(int'(cnt) + int'($urandom_range(0, 3)));
        default: if (cnt != 0) exc = EXC_W'($urandom_range(0, int'(cnt) - 1));
      endcase
      if (cnt != 0 && pick < 7) begin
        lim = (cnt > MAX_POINTS) ? MAX_POINTS : int'(cnt);
        n = $urandom_range(0, lim - 1);
        x = coord_t'(int'(point_x[n]) + int'($urandom_range(0, 2 * span)) - span);
        y = coord_t'(int'(point_y[n]) + int'($urandom_range(0, 2 * span)) - span);
        // same point seen through the wrap
        if (pick == 0) x = coord_t'(int'(x) + int'(field_w) * 16);
        if (pick == 1) y = coord_t'(int'(y) - int'(field_h) * 16);
      end
    end
    send_word(op, idx, x, y, cnt, exc, 1'b0, 1'b0);
    random_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_flags.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [REG_IDX_W-1:0] which,
                           input logic [CFG_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {which, 2'b00};
    pwdata  <= PDATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (which)
      REG_FIELD_WIDTH:  field_w = value;
      REG_FIELD_HEIGHT: field_h = value;
      REG_MIN_SPACING:  spacing = value;
      default: ;
    endcase
    // read back
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[CFG_W-1:0] !== value) begin
      $error("prdata mismatch at reg %0d: expected %0d, got %0d",
             which, value, prdata[CFG_W-1:0]);
      error_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic choose_field_setup();
    logic [CFG_W-1:0] w;
    logic [CFG_W-1:0] h;
    logic [CFG_W-1:0] s;
    case ($urandom_range(0, 5))
      0: w = 12'd1;
      1: w = 12'd4095;
      2: w = FIELD_WIDTH_RST;
      default: w = CFG_W'($urandom_range(1, 4095));
    endcase
    case ($urandom_range(0, 5))
      0: h = 12'd1;
      1: h = 12'd4095;
      2: h = FIELD_HEIGHT_RST;
      default: h = CFG_W'($urandom_range(1, 4095));
    endcase
    case ($urandom_range(0, 5))
      0: s = 12'd0;
      1: s = 12'd4095;
      2: s = MIN_SPACING_RST;
      default: s = CFG_W'($urandom_range(1, 1023));
    endcase
    cfg_write(REG_FIELD_WIDTH, w);
    cfg_write(REG_FIELD_HEIGHT, h);
    cfg_write(REG_MIN_SPACING, s);
  endtask

  // receiver: random stall patterns plus one long hold-off on request
  initial begin : receiver
    int mode;
    int span;
    int k;
    int tick;
    tick = 0;
    wait (rst_n);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 200);
      k = 0;
      while (k < span && !hold_request) begin
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(0, 3) != 0);
          2: out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= tick[1] ^ tick[3];
        endcase
        @(posedge clk);
        tick++;
        k++;
      end
    end
  end

  always @(posedge clk) begin : result_check
    bit want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_flags.size() == 0) begin
        $error("out word with no query pending: too_close=%0d", out_too_close);
        error_count++;
      end else begin
        want = expected_flags.pop_front();
        if (out_too_close !== want) begin
          $error("too_close mismatch: expected %0d, got %0d", want, out_too_close);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (psel && penable && pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int phase;
    int len;
    directed = '{
      store_row(0, 0, 0),
      checked_row(0, 0, 1, 2047, 1'b1),
      checked_row(0, 0, 0, 0, 1'b0),
      checked_row(0, 0, 1, 0, 1'b0),
      store_row(1, 32767, 32767),
      store_row(2, -32768, -32768),
      store_row(1023, 16, -16),
      store_row(3, 16368, 16368),
      query_row(0, 0, 4, 0),
      query_row(-32768, -32768, 3, 2),
      query_row(32767, 32767, 3, 1),
      checked_row(256, 0, 1, 1, 1'b1),
      checked_row(257, 0, 1, 2047, 1'b0),
      setting_row(REG_MIN_SPACING, 0),
      checked_row(0, 0, 1, 1, 1'b1),
      checked_row(1, 0, 1, 1, 1'b0),
      setting_row(REG_FIELD_WIDTH, 0),
      query_row(1, 0, 1, 1),
      setting_row(REG_MIN_SPACING, 4095),
      query_row(-32768, 100, 3, 2047),
      setting_row(REG_FIELD_WIDTH, 4095),
      setting_row(REG_FIELD_HEIGHT, 1),
      query_row(32767, -32768, 4, 1024)
    };
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) begin
      if (directed[i].kind == ROW_CFG) begin
        wait_drained();
        cfg_write(directed[i].which, directed[i].value);
      end else begin
        send_word(directed[i].op, directed[i].idx, directed[i].x, directed[i].y,
                  directed[i].cnt, directed[i].exc, directed[i].known, directed[i].hit);
      end
    end

    phase = 0;
    while (random_sent < RANDOM_WORDS) begin
      wait_drained();
      choose_field_setup();
      if (phase == 2) begin
        // back up the input while the receiver holds off
        hold_request = 1'b1;
        steady = 1'b1;
        repeat (8) send_random(1'b1);
        steady = 1'b0;
      end else if (phase == 4) begin
        while (fill_mark < FILL_TARGET) begin
          send_word(OP_STORE, IDX_W'(fill_mark), coord_t'($urandom), coord_t'($urandom),
                    '0, '0, 1'b0, 1'b0);
          random_sent++;
        end
      end
      len = $urandom_range(30, 70);
      repeat (len) send_random(1'b0);
      phase++;
    end

    wait_drained();
    repeat (300) @(posedge clk);
    if (error_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
`default_nettype wire

FILE: filelist.f
rtl/tmsc_pkg.sv
rtl/tmsc_cell.sv
rtl/toroidal_min_spacing_check.sv
bench/toroidal_min_spacing_check_test.sv
